/* rtl/pab_pkg.sv */
// package for the proximity alert beeper: level codes, register indexes,
// queue entry type and back-end state type. no dependencies
package pab_pkg;

  typedef enum logic [1:0] {
    LVL_NONE   = 2'd0,
    LVL_WARN   = 2'd1,
    LVL_DANGER = 2'd2,
    LVL_CRIT   = 2'd3
  } level_e;

  localparam logic CFG_MARGIN  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] DEFAULT_MARGIN = 16'd160;
  localparam logic [31:0] TIMEOUT_RESET  = 32'd60000;
  localparam logic [9:0]  WARN_SPAN      = 10'd700;
  localparam logic [9:0]  WARN_BASE      = 10'd100;
  localparam logic [9:0]  DANGER_MS      = 10'd80;

  localparam int NUM_W  = 26;
  localparam int QUOT_W = 10;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    level_e             level;
    logic [NUM_W-1:0]   num;
    logic [15:0]        margin;
    logic [31:0]        now;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } back_st_e;

endpackage

/* rtl/pab_front.sv */
// front end: accepts update transactions, clamps the distance and forms
// the warning numerator. depends on pab_pkg
module pab_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           level_i,
  input  logic signed [15:0]   distance_i,
  input  logic [31:0]          now_ms_i,
  input  logic [15:0]          margin_cfg_i,
  output logic                 push_o,
  output pab_pkg::item_t       item_o,
  input  logic                 full_i
);
  import pab_pkg::*;

  logic        valid_q, valid_d;
  item_t       item_q, item_d;
  logic [15:0] margin;
  logic [15:0] clamp_dist;
  logic        accept;

  assign margin = (margin_cfg_i == 16'd0) ? DEFAULT_MARGIN : margin_cfg_i;

  always_comb begin
    if (distance_i[15]) begin
      clamp_dist = 16'd0;
    end else if ($unsigned(distance_i) > margin) begin
      clamp_dist = margin;
    end else begin
      clamp_dist = $unsigned(distance_i);
    end
  end

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_d = item_q;
    if (accept) begin
      item_d.level  = level_e'(level_i);
      item_d.num    = NUM_W'(clamp_dist * WARN_SPAN);
      item_d.margin = margin;
      item_d.now    = now_ms_i;
    end
  end

  assign valid_d = accept || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;

endmodule

/* rtl/pab_fifo.sv */
// short queue between front and back end
// depends on pab_pkg
module pab_fifo #(
  parameter int Depth = pab_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pab_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output pab_pkg::item_t  item_o,
  output logic            empty_o
);
  import pab_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/pab_back.sv */
// back end: serial interval divider, alert state update and result register
// depends on pab_pkg
module pab_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pab_pkg::item_t  item_i,
  output logic            pop_o,
  input  logic [31:0]     timeout_cfg_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            status_led_o,
  output logic            buzzer_on_o,
  output logic [9:0]      blink_interval_o
);
  import pab_pkg::*;

  back_st_e          st_q, st_d;
  item_t             work_q;
  logic [NUM_W-1:0]  rem_q, dv_q;
  logic [QUOT_W-1:0] quot_q;
  logic [3:0]        cnt_q;
  logic              exec;
  logic              div_step;

  level_e      lvl_q;
  logic [31:0] start_q, toggle_q;
  logic        phase_q, buz_q, led_q;

  logic        out_valid_q;
  logic        led_out_q, buz_out_q;
  logic [9:0]  intv_out_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          st_d = (item_i.level == LVL_WARN) ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        if (cnt_q == 4'd0) begin
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    pop_o    = 1'b0;
    div_step = 1'b0;
    exec     = 1'b0;
    unique case (st_q)
      ST_IDLE: pop_o    = !empty_i;
      ST_DIV:  div_step = 1'b1;
      ST_EXEC: exec     = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic             ge;
  logic [NUM_W-1:0] rem_sub;
  assign ge      = (rem_q >= dv_q);
  assign rem_sub = rem_q - dv_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= item_i;
      rem_q  <= item_i.num;
      dv_q   <= NUM_W'({item_i.margin, 9'd0});
      quot_q <= '0;
      cnt_q  <= 4'd9;
    end else if (div_step) begin
      if (ge) begin
        rem_q <= rem_sub;
      end
      quot_q <= {quot_q[QUOT_W-2:0], ge};
      dv_q   <= dv_q >> 1;
      cnt_q  <= cnt_q - 4'd1;
    end
  end

  // state update
  logic        chg;
  logic [31:0] start_e, toggle_e;
  logic        phase_e;
  logic        timed_out;
  logic [9:0]  intv;
  logic        lvl_none, lvl_crit;

  logic [31:0] start_nx, toggle_nx;
  logic        phase_nx, buz_nx, led_nx;

  assign chg      = (work_q.level != lvl_q);
  assign start_e  = chg ? work_q.now : start_q;
  assign toggle_e = chg ? 32'd0 : toggle_q;
  assign phase_e  = chg ? 1'b0 : phase_q;
  assign lvl_none = (work_q.level == LVL_NONE);
  assign lvl_crit = (work_q.level == LVL_CRIT);
  assign timed_out = (work_q.now - start_e) >= timeout_cfg_i;

  always_comb begin
    case (work_q.level)
      LVL_WARN:   intv = WARN_BASE + quot_q;
      LVL_DANGER: intv = DANGER_MS;
      default:    intv = 10'd0;
    endcase
  end

  always_comb begin
    start_nx  = start_e;
    toggle_nx = toggle_e;
    phase_nx  = phase_e;
    buz_nx    = buz_q;
    led_nx    = led_q;
    if (lvl_none) begin
      start_nx  = 32'd0;
      toggle_nx = 32'd0;
      phase_nx  = 1'b0;
      buz_nx    = 1'b0;
      led_nx    = 1'b0;
    end else if (lvl_crit) begin
      led_nx = 1'b1;
      buz_nx = !timed_out;
    end else if ((work_q.now - toggle_e) >= {22'd0, intv}) begin
      toggle_nx = work_q.now;
      phase_nx  = !phase_e;
      led_nx    = !phase_e;
      buz_nx    = !phase_e && !timed_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q    <= LVL_NONE;
      start_q  <= 32'd0;
      toggle_q <= 32'd0;
      phase_q  <= 1'b0;
      buz_q    <= 1'b0;
      led_q    <= 1'b0;
    end else if (exec) begin
      lvl_q    <= work_q.level;
      start_q  <= start_nx;
      toggle_q <= toggle_nx;
      phase_q  <= phase_nx;
      buz_q    <= buz_nx;
      led_q    <= led_nx;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      led_out_q  <= led_nx;
      buz_out_q  <= buz_nx;
      intv_out_q <= intv;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_led_o     = led_out_q;
  assign buzzer_on_o      = buz_out_q;
  assign blink_interval_o = intv_out_q;

endmodule

/* rtl/proximity_alert_beeper_unit.sv */
// top level of the proximity alert beeper: configuration registers, front end,
// queue and back end. depends on pab_pkg, pab_front, pab_fifo, pab_back
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  level_i, distance_i, now_ms_i
//   out      output     out_valid_o/out_stall_i status_led_o, buzzer_on_o,
//                                              blink_interval_o
//   cfg      input      cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// a warning transaction passes through the back end as a pop, the serial divider
// of the interval and an update; other levels go from the pop to the update.
// the front end adds one register stage; the queue lets it keep accepting while it has room.
// rst_ni is asynchronous active low: all alert state clears, margin resets
// to 0 and the buzzer timeout to 60000 ms.
// a stalled output holds its result; the back end waits for the register.
module proximity_alert_beeper_unit #(
  parameter int QueueDepth = pab_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         level_i,
  input  logic signed [15:0] distance_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_led_o,
  output logic               buzzer_on_o,
  output logic [9:0]         blink_interval_o
);
  import pab_pkg::*;

  logic [15:0] margin_q;
  logic [31:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q  <= 16'd0;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MARGIN:  margin_q  <= cfg_wdata_i[15:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  item_t front_item, queue_item;
  logic  push, full, pop, empty;

  pab_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .level_i      (level_i),
    .distance_i   (distance_i),
    .now_ms_i     (now_ms_i),
    .margin_cfg_i (margin_q),
    .push_o       (push),
    .item_o       (front_item),
    .full_i       (full)
  );

  pab_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  pab_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .item_i           (queue_item),
    .pop_o            (pop),
    .timeout_cfg_i    (timeout_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_led_o     (status_led_o),
    .buzzer_on_o      (buzzer_on_o),
    .blink_interval_o (blink_interval_o)
  );

endmodule

/* tb/proximity_alert_beeper_unit_tb.sv */
`timescale 1ns / 1ps
// testbench for proximity_alert_beeper_unit: directed and random update
// transactions against a cycle-free predictor held in a scoreboard class.
// depends on pab_pkg and the rtl of the beeper unit
module proximity_alert_beeper_unit_tb;
  import pab_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 290;
  localparam int NUM_PHASES     = 6;

  typedef struct {
    logic       led;
    logic       buzz;
    logic [9:0] interval;
  } alert_t;

  class alert_scoreboard;
    logic [15:0] margin_reg;
    logic [31:0] timeout_reg;
    level_e      act_lvl;
    logic [31:0] lvl_start;
    logic [31:0] last_toggle;
    logic        phase;
    logic        buzz;
    logic        led;
    alert_t      pending_alerts[$];
    int          errors;

    function void clear();
      margin_reg  = '0;
      timeout_reg = TIMEOUT_RESET;
      act_lvl     = LVL_NONE;
      lvl_start   = '0;
      last_toggle = '0;
      phase       = 1'b0;
      buzz        = 1'b0;
      led         = 1'b0;
      errors      = 0;
      pending_alerts.delete();
    endfunction

    function void set_regs(logic [15:0] margin, logic [31:0] timeout);
      margin_reg  = margin;
      timeout_reg = timeout;
    endfunction

    function int pending();
      return pending_alerts.size();
    endfunction

    function void note_update(logic [1:0] lvl_in, logic [15:0] dist_in, logic [31:0] now);
      alert_t      res;
      logic [31:0] intv;
      logic [31:0] m;
      logic [31:0] d;
      bit          timed_out;
      intv = '0;
      if (level_e'(lvl_in) != act_lvl) begin
        act_lvl     = level_e'(lvl_in);
        lvl_start   = now;
        last_toggle = '0;
        phase       = 1'b0;
      end
      if (act_lvl == LVL_NONE) begin
        led         = 1'b0;
        buzz        = 1'b0;
        lvl_start   = '0;
        last_toggle = '0;
        phase       = 1'b0;
      end else begin
        timed_out = (now - lvl_start) >= timeout_reg;
        if (act_lvl == LVL_CRIT) begin
          led  = 1'b1;
          buzz = !timed_out;
        end else begin
          if (act_lvl == LVL_WARN) begin
            m = (margin_reg == 16'd0) ? {16'd0, DEFAULT_MARGIN} : {16'd0, margin_reg};
            d = dist_in[15] ? 32'd0 : {16'd0, dist_in};
            if (d > m) d = m;
            intv = WARN_BASE + (d * WARN_SPAN) / m;
          end else begin
            intv = DANGER_MS;
          end
          if ((now - last_toggle) >= intv) begin
            last_toggle = now;
            phase       = !phase;
            led         = phase;
            buzz        = phase && !timed_out;
          end
        end
      end
      res.led      = led;
      res.buzz     = buzz;
      res.interval = intv[9:0];
      pending_alerts.push_back(res);
    endfunction

    function void check_alert(logic led_o, logic buzz_o, logic [9:0] intv_o);
      alert_t res;
      if (pending_alerts.size() == 0) begin
        $display("%0t: unexpected result led %0b buzzer %0b interval %0d",
                 $time, led_o, buzz_o, intv_o);
        errors++;
        return;
      end
      res = pending_alerts.pop_front();
      if (led_o !== res.led) begin
        $display("%0t: status_led expected %0b got %0b", $time, res.led, led_o);
        errors++;
      end
      if (buzz_o !== res.buzz) begin
        $display("%0t: buzzer_on expected %0b got %0b", $time, res.buzz, buzz_o);
        errors++;
      end
      if (intv_o !== res.interval) begin
        $display("%0t: blink_interval expected %0d got %0d", $time, res.interval, intv_o);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_MARGIN;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         level_i = LVL_NONE;
  logic signed [15:0] distance_i = '0;
  logic [31:0]        now_ms_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               status_led_o;
  logic               buzzer_on_o;
  logic [9:0]         blink_interval_o;

  alert_scoreboard sb = new();
  int              tx_pct = 0;
  int              rx_pct = 0;
  logic            hold_req = 1'b0;
  int              idle_cycles = 0;
  logic [15:0]     cur_margin = '0;
  logic [31:0]     cur_now = '0;
  level_e          cur_lvl = LVL_NONE;

  proximity_alert_beeper_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .level_i         (level_i),
    .distance_i      (distance_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_led_o    (status_led_o),
    .buzzer_on_o     (buzzer_on_o),
    .blink_interval_o(blink_interval_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_update(level_i, distance_i, now_ms_i);
      if (out_valid_o && !out_stall_i) sb.check_alert(status_led_o, buzzer_on_o, blink_interval_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= (rx_pct != 0) && ($urandom_range(99, 0) < rx_pct);
    end
  end

  task automatic send_item(level_e lvl, logic [15:0] dist_in, logic [31:0] now);
    while (tx_pct != 0 && $urandom_range(99, 0) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    distance_i <= dist_in;
    now_ms_i   <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [15:0] margin, logic [31:0] timeout);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MARGIN;
    cfg_wdata_i <= {16'd0, margin};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TIMEOUT;
    cfg_wdata_i <= timeout;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_regs(margin, timeout);
    cur_margin = margin;
  endtask

  function automatic logic [15:0] pick_distance();
    int unsigned r;
    logic [31:0] top;
    logic [31:0] v;
    r   = $urandom_range(99, 0);
    top = (cur_margin == 16'd0) ? {16'd0, DEFAULT_MARGIN} : {16'd0, cur_margin};
    if (top > 32'd32767) top = 32'd32767;
    if (r < 65) v = $urandom_range(top, 0);
    else if (r < 75) v = top;
    else if (r < 88) v = 32'h8000 | $urandom_range(32'h7FFF, 0);
    else v = $urandom;
    return v[15:0];
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 80) cur_now = cur_now + $urandom_range(220, 0);
    else if (r < 95) cur_now = cur_now + $urandom_range(2000, 0);
    else if (r < 98) cur_now = cur_now + $urandom_range(120000, 0);
    else cur_now = $urandom;
    if ($urandom_range(99, 0) < 10) cur_lvl = level_e'($urandom_range(3, 0));
    send_item(cur_lvl, pick_distance(), cur_now);
  endtask

  initial begin
    logic [15:0] margins [NUM_PHASES];
    logic [31:0] timeouts [NUM_PHASES];
    margins  = '{16'd0, 16'd1, 16'hFFFF, 16'd160, 16'd37, 16'd0};
    timeouts = '{32'd1, 32'hFFFF_FFFF, 32'd60000, 32'd300, 32'd0, 32'd0};
    margins[5]  = 16'($urandom_range(400, 1));
    timeouts[5] = $urandom_range(2000, 1);
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_pct = 15;
    rx_pct = 68;
    send_item(LVL_NONE, 16'd0, 32'd0);
    send_item(LVL_WARN, 16'h7FFF, 32'd1000);
    send_item(LVL_WARN, 16'h8000, 32'd1050);
    send_item(LVL_WARN, 16'd0, 32'd1100);
    send_item(LVL_WARN, 16'd159, 32'd1900);
    send_item(LVL_DANGER, 16'd160, 32'd1950);
    send_item(LVL_DANGER, 16'd161, 32'd2000);
    send_item(LVL_DANGER, 16'd5, 32'd2030);
    send_item(LVL_CRIT, 16'd0, 32'd2040);
    send_item(LVL_CRIT, 16'd0, 32'd62039);
    send_item(LVL_CRIT, 16'd0, 32'd62040);
    send_item(LVL_WARN, 16'd80, 32'd70000);
    send_item(LVL_NONE, 16'd5, 32'd70050);
    send_item(LVL_WARN, 16'd1, 32'hFFFF_FFF0);
    send_item(LVL_WARN, 16'd1, 32'h0000_0050);
    send_item(LVL_WARN, 16'd1, 32'h0000_00A0);
    send_item(LVL_DANGER, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(LVL_NONE, 16'h8000, 32'hFFFF_FFFF);
    // level change between toggles keeps the previous drive
    send_item(LVL_CRIT, 16'hFFFF, 32'd0);
    send_item(LVL_WARN, 16'd0, 32'd50);
    send_item(LVL_DANGER, 16'd0, 32'd60);
    settle();
    load_regs(16'hFFFF, 32'd0);
    send_item(LVL_WARN, 16'h7FFF, 32'd5000);
    send_item(LVL_CRIT, 16'd0, 32'd5001);
    send_item(LVL_DANGER, 16'd0, 32'd6000);
    send_item(LVL_NONE, 16'd0, 32'd6100);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_regs(margins[p], timeouts[p]);
      tx_pct  = (p < 2) ? 15 : (p < 4) ? 68 : 0;
      rx_pct  = (p < 2) ? 68 : (p < 4) ? 15 : 0;
      cur_now = p[0] ? (32'hFFFF_FFFF - $urandom_range(5000, 0)) : $urandom;
      cur_lvl = level_e'($urandom_range(3, 0));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 1 || p == 4) && i == 100) hold_req = 1'b1;
        random_item();
      end
      settle();
    end

    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* proximity_alert_beeper_unit.f */
rtl/pab_pkg.sv
rtl/pab_front.sv
rtl/pab_fifo.sv
rtl/pab_back.sv
rtl/proximity_alert_beeper_unit.sv
tb/proximity_alert_beeper_unit_tb.sv
